### src/http_chunked_body_decoder_macros.svh
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/hcbd_pkg.sv
// Types, constants and helper functions for the chunked body decoder.
package hcbd_pkg;

   // Field and state widths.
   localparam int BYTE_W        = 8;
   localparam int KIND_W        = 2;
   localparam int KIB_W         = 22;
   localparam int TRAILER_W     = 16;
   localparam int CSR_DATA_W    = 22;
   localparam int CSR_INDEX_W   = 1;
   localparam int CHUNK_W       = 63;
   localparam int TOTAL_W       = 63;
   localparam int MATCH_W       = 2;

   // Size lines must be shorter than this many bytes.
   localparam int MAX_LINE_BYTES = 1024;
   localparam int LINE_W         = $clog2(MAX_LINE_BYTES + 1);

   // Reset value of the trailer byte limit.
   localparam logic [TRAILER_W-1:0] TRAILER_LIMIT_RESET = TRAILER_W'(8192);

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BODY_KIB      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TRAILER_BYTES = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   // Error codes.
   localparam logic ERR_BAD_REQUEST = 1'b0;
   localparam logic ERR_TOO_LARGE   = 1'b1;

   // Input actions.
   localparam logic ACT_BYTE  = 1'b0;
   localparam logic ACT_BEGIN = 1'b1;

   // Terminator progress through CR LF CR LF.
   localparam logic [MATCH_W-1:0] MATCH_NONE   = 2'd0;
   localparam logic [MATCH_W-1:0] MATCH_CR     = 2'd1;
   localparam logic [MATCH_W-1:0] MATCH_CRLF   = 2'd2;
   localparam logic [MATCH_W-1:0] MATCH_CRLFCR = 2'd3;

   // Character codes.
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;

   // Decoder phases, one-hot.
   typedef enum logic [8:0] {
      PH_SIZE_START  = 9'b000000001,
      PH_SIZE_DIGITS = 9'b000000010,
      PH_SIZE_BLANK  = 9'b000000100,
      PH_SIZE_CR     = 9'b000001000,
      PH_SIZE_EXT    = 9'b000010000,
      PH_DATA        = 9'b000100000,
      PH_DATA_CR     = 9'b001000000,
      PH_DATA_LF     = 9'b010000000,
      PH_TRAILER     = 9'b100000000
   } phase_type;

   // A decoded hex digit.
   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // Decodes one ASCII hex digit of either case.
   function automatic hex_type hex_value(input logic [BYTE_W-1:0] b);
      hex_type h;
      h.ok    = 1'b0;
      h.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.ok    = 1'b1;
         h.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.ok    = 1'b1;
         h.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.ok    = 1'b1;
         h.value = 4'(b - 8'h37);
      end
      return h;
   endfunction

endpackage

### src/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder: one received byte in, at most one result out.
// An accepted item is held in the input register and decoded from there into the
// result register once the result register is free.
// Throughput: one item per clock; the result register stall is the only limit.
// Reset clears the parse state, sets the body limit to unlimited and the
// trailer limit to 8192 bytes.
`include "http_chunked_body_decoder_macros.svh"

module http_chunked_body_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [hcbd_pkg::BYTE_W-1:0]        req_in_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hcbd_pkg::KIND_W-1:0]        rsp_kind,
   output logic [hcbd_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                               rsp_error_code,
   output logic [hcbd_pkg::TOTAL_W-1:0]       rsp_body_length,
   output logic                               rsp_keep_alive_dropped,
   input  logic                               csr_write,
   input  logic [hcbd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hcbd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hcbd_pkg::*;

   // Configuration registers.
   logic [KIB_W-1:0]     max_body_kib_ff;
   logic [TRAILER_W-1:0] max_trailer_ff;

   // Input register.
   logic              in_valid_ff;
   logic              in_action_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // Parse state.
   phase_type           phase_ff,    phase_in;
   logic [CHUNK_W-1:0]  chunk_ff,    chunk_in;
   logic [TOTAL_W-1:0]  total_ff,    total_in;
   logic [LINE_W-1:0]   line_ff,     line_in;
   logic [TRAILER_W-1:0] trailer_ff, trailer_in;
   logic [MATCH_W-1:0]  match_ff,    match_in;
   logic                finished_ff, finished_in;

   // Result register.
   logic                rsp_valid_ff;
   logic [KIND_W-1:0]   rsp_kind_ff,  res_kind;
   logic [BYTE_W-1:0]   rsp_byte_ff,  res_byte;
   logic                rsp_code_ff,  res_code;
   logic [TOTAL_W-1:0]  rsp_len_ff,   res_len;
   logic                rsp_drop_ff,  res_drop;
   logic                res_load;

   // Handshake and decode helpers.
   logic                 req_accept;
   logic                 out_free;
   logic                 advance;
   hex_type              hv;
   logic [LINE_W-1:0]    line_inc;
   logic [TRAILER_W-1:0] trailer_inc;
   logic [CHUNK_W:0]     size_sum;
   logic [CHUNK_W:0]     size_limit;
   logic                 size_too_large;
   logic                 bad;
   logic                 line_end;
   logic                 after_cr;

   // The item in the input register moves on when the result register is free.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_kib_ff <= '0;
         max_trailer_ff  <= TRAILER_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_BODY_KIB:      max_body_kib_ff <= csr_wdata[KIB_W-1:0];
            CSR_MAX_TRAILER_BYTES: max_trailer_ff  <= csr_wdata[TRAILER_W-1:0];
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_in_byte;
      end
   end

   // Shared arithmetic for the current byte.
   assign hv          = hex_value(in_byte_ff);
   assign line_inc    = line_ff + 1'b1;
   assign trailer_inc = (trailer_ff == '1) ? trailer_ff : trailer_ff + 1'b1;
   assign size_sum    = {1'b0, chunk_ff} + {1'b0, total_ff};
   assign size_limit  = (CHUNK_W + 1)'({max_body_kib_ff, 10'b0});

   // With a limit the chunk may not push the total past it; without one the
   // total must still fit in 63 bits.
   always_comb begin
      if (size_limit != '0) begin
         size_too_large = size_sum > size_limit;
      end else begin
         size_too_large = size_sum[CHUNK_W];
      end
   end

   // Next state and result for the item in the input register.
   always_comb begin
      phase_in    = phase_ff;
      chunk_in    = chunk_ff;
      total_in    = total_ff;
      line_in     = line_ff;
      trailer_in  = trailer_ff;
      match_in    = match_ff;
      finished_in = finished_ff;
      res_load    = 1'b0;
      res_kind    = KIND_PAYLOAD;
      res_byte    = '0;
      res_code    = ERR_BAD_REQUEST;
      res_len     = '0;
      res_drop    = 1'b0;
      bad         = 1'b0;
      line_end    = 1'b0;
      after_cr    = 1'b0;

      if (advance) begin
         if (in_action_ff == ACT_BEGIN) begin
            phase_in    = PH_SIZE_START;
            chunk_in    = '0;
            total_in    = '0;
            line_in     = '0;
            trailer_in  = '0;
            match_in    = MATCH_NONE;
            finished_in = 1'b0;
         end else if (!finished_ff) begin
            unique case (phase_ff) inside
               PH_DATA: begin
                  // Pass the payload byte through and count it.
                  if (chunk_ff != '0) begin
                     chunk_in = chunk_ff - 1'b1;
                  end
                  total_in = total_ff + 1'b1;
                  if (chunk_ff <= CHUNK_W'(1)) begin
                     phase_in = PH_DATA_CR;
                  end
                  res_load = 1'b1;
                  res_kind = KIND_PAYLOAD;
                  res_byte = in_byte_ff;
               end
               PH_DATA_CR: begin
                  if (in_byte_ff != CH_CR) begin
                     bad = 1'b1;
                  end else begin
                     phase_in = PH_DATA_LF;
                  end
               end
               PH_DATA_LF: begin
                  if (in_byte_ff != CH_LF) begin
                     bad = 1'b1;
                  end else begin
                     phase_in = PH_SIZE_START;
                     chunk_in = '0;
                     line_in  = '0;
                     match_in = MATCH_NONE;
                  end
               end
               PH_TRAILER: begin
                  // Track CR LF CR LF and cut overlong trailers.
                  if (in_byte_ff == CH_LF && match_ff == MATCH_CRLFCR) begin
                     finished_in = 1'b1;
                     res_load    = 1'b1;
                     res_kind    = KIND_DONE;
                     res_len     = total_ff;
                  end else begin
                     if (in_byte_ff == CH_CR) begin
                        match_in = (match_ff == MATCH_CRLF) ? MATCH_CRLFCR : MATCH_CR;
                     end else if (in_byte_ff == CH_LF) begin
                        match_in = (match_ff == MATCH_CR) ? MATCH_CRLF : MATCH_NONE;
                     end else begin
                        match_in = MATCH_NONE;
                     end
                     trailer_in = trailer_inc;
                     if (trailer_inc >= max_trailer_ff) begin
                        finished_in = 1'b1;
                        res_load    = 1'b1;
                        res_kind    = KIND_DONE;
                        res_len     = total_ff;
                        res_drop    = 1'b1;
                     end
                  end
               end
               PH_SIZE_START, PH_SIZE_DIGITS, PH_SIZE_BLANK, PH_SIZE_CR, PH_SIZE_EXT: begin
                  line_in = line_inc;
                  if ((phase_ff == PH_SIZE_START || phase_ff == PH_SIZE_DIGITS) && hv.ok) begin
                     // A digit while the size is above 2^59-1 would overflow.
                     if (chunk_ff[CHUNK_W-1:CHUNK_W-4] != '0) begin
                        bad = 1'b1;
                     end else begin
                        chunk_in = {chunk_ff[CHUNK_W-5:0], hv.value};
                        phase_in = PH_SIZE_DIGITS;
                     end
                  end else if (phase_ff == PH_SIZE_START) begin
                     bad = 1'b1;
                  end else if (phase_ff == PH_SIZE_DIGITS || phase_ff == PH_SIZE_BLANK) begin
                     if (in_byte_ff == CH_SPACE || in_byte_ff == CH_TAB) begin
                        phase_in = PH_SIZE_BLANK;
                     end else if (in_byte_ff == CH_CR) begin
                        phase_in = PH_SIZE_CR;
                     end else if (in_byte_ff == CH_SEMI) begin
                        phase_in = PH_SIZE_EXT;
                        match_in = MATCH_NONE;
                     end else begin
                        bad = 1'b1;
                     end
                  end else if (phase_ff == PH_SIZE_CR) begin
                     if (in_byte_ff == CH_LF) begin
                        line_end = 1'b1;
                        after_cr = 1'b1;
                     end else begin
                        bad = 1'b1;
                     end
                  end else begin
                     // Extensions are skipped up to an LF, bare or after CR.
                     if (in_byte_ff == CH_LF) begin
                        line_end = 1'b1;
                        after_cr = (match_ff == MATCH_CR);
                     end else begin
                        match_in = (in_byte_ff == CH_CR) ? MATCH_CR : MATCH_NONE;
                     end
                  end

                  // Line length check, then the end of the size line.
                  if (!bad && line_inc >= LINE_W'(MAX_LINE_BYTES)) begin
                     bad = 1'b1;
                  end
                  if (!bad && line_end) begin
                     if (chunk_ff == '0) begin
                        phase_in   = PH_TRAILER;
                        trailer_in = '0;
                        match_in   = after_cr ? MATCH_CRLF : MATCH_NONE;
                     end else if (size_too_large) begin
                        finished_in = 1'b1;
                        res_load    = 1'b1;
                        res_kind    = KIND_ERROR;
                        res_code    = ERR_TOO_LARGE;
                        res_drop    = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               default: begin
                  phase_in = PH_SIZE_START;
               end
            endcase

            // Any bad request ends the body with an error.
            if (bad) begin
               finished_in = 1'b1;
               res_load    = 1'b1;
               res_kind    = KIND_ERROR;
               res_code    = ERR_BAD_REQUEST;
               res_drop    = 1'b1;
               res_byte    = '0;
               res_len     = '0;
            end
         end
      end
   end

   // Parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SIZE_START;
         chunk_ff    <= '0;
         total_ff    <= '0;
         line_ff     <= '0;
         trailer_ff  <= '0;
         match_ff    <= MATCH_NONE;
         finished_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         chunk_ff    <= chunk_in;
         total_ff    <= total_in;
         line_ff     <= line_in;
         trailer_ff  <= trailer_in;
         match_ff    <= match_in;
         finished_ff <= finished_in;
      end
   end

   // Result register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance && res_load) begin
         rsp_kind_ff <= res_kind;
         rsp_byte_ff <= res_byte;
         rsp_code_ff <= res_code;
         rsp_len_ff  <= res_len;
         rsp_drop_ff <= res_drop;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_kind               = rsp_kind_ff;
   assign rsp_out_byte           = rsp_byte_ff;
   assign rsp_error_code         = rsp_code_ff;
   assign rsp_body_length        = rsp_len_ff;
   assign rsp_keep_alive_dropped = rsp_drop_ff;

   // A begin item never produces a result.
   `HCBD_ASSERT_SAME(a_begin_silent, clock, reset, advance && in_action_ff == ACT_BEGIN, !res_load, "begin item produced a result")
   // Done and error results always close the body.
   `HCBD_ASSERT_NEXT(a_end_closes, clock, reset, advance && res_load && res_kind != KIND_PAYLOAD, finished_ff, "body not closed after done or error")
   // Payload phase is only entered with bytes left in the chunk.
   `HCBD_ASSERT_SAME(a_data_nonzero, clock, reset, phase_ff == PH_DATA, chunk_ff != '0, "payload phase with empty chunk")
   // The size line counter never reaches the line limit.
   `HCBD_ASSERT_SAME(a_line_bound, clock, reset, !finished_ff, line_ff < LINE_W'(MAX_LINE_BYTES), "size line counter out of range")

endmodule

### tb/chunked_decode_checker.sv
// Checker for the chunked body decoder: predicts every result and compares it on the result port.
module chunked_decode_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_action,
   input  logic [hcbd_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [hcbd_pkg::KIND_W-1:0]      rsp_kind,
   input  logic [hcbd_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  logic                             rsp_error_code,
   input  logic [hcbd_pkg::TOTAL_W-1:0]     rsp_body_length,
   input  logic                             rsp_keep_alive_dropped,
   input  logic                             csr_write,
   input  logic [hcbd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hcbd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               expected_count,
   output int                               fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hcbd_pkg::*;

   // A size may take another digit only while it is at most 2^59-1.
   localparam logic [63:0] SIZE_GUARD = (64'd1 << 59) - 64'd1;
   localparam logic [63:0] TOTAL_MAX  = {1'b0, {63{1'b1}}};

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  out_byte;
      logic               error_code;
      logic [TOTAL_W-1:0] body_length;
      logic               keep_alive_dropped;
   } body_result_type;

   // Register copies.
   logic [KIB_W-1:0]     body_kib_limit;
   logic [TRAILER_W-1:0] trailer_byte_limit;

   // Parse state of the body being decoded.
   phase_type            parse_phase;
   logic [63:0]          chunk_left;
   logic [TOTAL_W-1:0]   payload_total;
   int unsigned          line_bytes;
   int unsigned          trailer_bytes;
   logic [MATCH_W-1:0]   crlf_progress;
   bit                   body_ended;

   body_result_type      awaited_results[$];
   int                   mismatches = 0;

   function automatic void clear_body_state();
      parse_phase   = PH_SIZE_START;
      chunk_left    = '0;
      payload_total = '0;
      line_bytes    = 0;
      trailer_bytes = 0;
      crlf_progress = MATCH_NONE;
      body_ended    = 1'b0;
   endfunction

   function automatic int digit_of(input logic [BYTE_W-1:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h57);
      if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h37);
      return -1;
   endfunction

   // Any error ends the body and drops keep-alive.
   function automatic bit raise_error(input logic code, output body_result_type r);
      body_ended           = 1'b1;
      r                    = '0;
      r.kind               = KIND_ERROR;
      r.error_code         = code;
      r.keep_alive_dropped = 1'b1;
      return 1'b1;
   endfunction

   // A size line has ended: either the trailers start or the size limit is applied.
   function automatic bit end_size_line(input bit after_cr, output body_result_type r);
      logic [63:0] limit;
      r = '0;
      if (chunk_left == 0) begin
         parse_phase   = PH_TRAILER;
         trailer_bytes = 0;
         crlf_progress = after_cr ? MATCH_CRLF : MATCH_NONE;
         return 1'b0;
      end
      limit = 64'(body_kib_limit) << 10;
      if (limit != 0) begin
         if (limit < chunk_left || limit - chunk_left < 64'(payload_total))
            return raise_error(ERR_TOO_LARGE, r);
      end else if (chunk_left > TOTAL_MAX - 64'(payload_total)) begin
         return raise_error(ERR_TOO_LARGE, r);
      end
      parse_phase = PH_DATA;
      return 1'b0;
   endfunction

   // One byte of a size line: digits, blanks, CR LF or an extension.
   function automatic bit size_line_step(input logic [BYTE_W-1:0] b,
                                         output body_result_type r);
      int digit;
      bit bad;
      bit line_end;
      bit after_cr;
      bit blank_rules;
      digit       = digit_of(b);
      bad         = 1'b0;
      line_end    = 1'b0;
      after_cr    = 1'b0;
      blank_rules = (parse_phase == PH_SIZE_BLANK);
      r           = '0;
      if (line_bytes < 32'hFF_FFFF) line_bytes++;
      case (parse_phase)
         PH_SIZE_START, PH_SIZE_DIGITS: begin
            if (digit >= 0) begin
               if (chunk_left > SIZE_GUARD) return raise_error(ERR_BAD_REQUEST, r);
               chunk_left  = (chunk_left << 4) | 64'(digit);
               parse_phase = PH_SIZE_DIGITS;
            end else if (parse_phase == PH_SIZE_START) begin
               bad = 1'b1;
            end else begin
               blank_rules = 1'b1;
            end
         end
         PH_SIZE_CR: begin
            if (b == CH_LF) begin
               line_end = 1'b1;
               after_cr = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         PH_SIZE_EXT: begin
            if (b == CH_LF) begin
               line_end = 1'b1;
               after_cr = (crlf_progress == MATCH_CR);
            end else begin
               crlf_progress = (b == CH_CR) ? MATCH_CR : MATCH_NONE;
            end
         end
         default: ;
      endcase
      // After the digits only blanks, CR or a semicolon may follow.
      if (blank_rules) begin
         if (b == CH_SPACE || b == CH_TAB) begin
            parse_phase = PH_SIZE_BLANK;
         end else if (b == CH_CR) begin
            parse_phase = PH_SIZE_CR;
         end else if (b == CH_SEMI) begin
            parse_phase   = PH_SIZE_EXT;
            crlf_progress = MATCH_NONE;
         end else begin
            bad = 1'b1;
         end
      end
      if (bad || line_bytes >= MAX_LINE_BYTES) return raise_error(ERR_BAD_REQUEST, r);
      if (line_end) return end_size_line(after_cr, r);
      return 1'b0;
   endfunction

   // One trailer byte: look for CR LF CR LF and count the rest against the limit.
   function automatic bit trailer_step(input logic [BYTE_W-1:0] b, output body_result_type r);
      r = '0;
      if (b == CH_CR) begin
         crlf_progress = (crlf_progress == MATCH_CRLF) ? MATCH_CRLFCR : MATCH_CR;
      end else if (b == CH_LF) begin
         if (crlf_progress == MATCH_CRLFCR) begin
            body_ended    = 1'b1;
            r.kind        = KIND_DONE;
            r.body_length = payload_total;
            return 1'b1;
         end
         crlf_progress = (crlf_progress == MATCH_CR) ? MATCH_CRLF : MATCH_NONE;
      end else begin
         crlf_progress = MATCH_NONE;
      end
      if (trailer_bytes < 32'hFFFF) trailer_bytes++;
      if (trailer_bytes >= trailer_byte_limit) begin
         body_ended           = 1'b1;
         r.kind               = KIND_DONE;
         r.body_length        = payload_total;
         r.keep_alive_dropped = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Decodes one accepted item; returns 1 when it causes a result.
   function automatic bit decode_item(input logic act, input logic [BYTE_W-1:0] b,
                                      output body_result_type r);
      r = '0;
      if (act == ACT_BEGIN) begin
         clear_body_state();
         return 1'b0;
      end
      if (body_ended) return 1'b0;
      case (parse_phase)
         PH_DATA: begin
            if (chunk_left != 0) chunk_left--;
            payload_total++;
            if (chunk_left == 0) parse_phase = PH_DATA_CR;
            r.kind     = KIND_PAYLOAD;
            r.out_byte = b;
            return 1'b1;
         end
         PH_DATA_CR: begin
            if (b != CH_CR) return raise_error(ERR_BAD_REQUEST, r);
            parse_phase = PH_DATA_LF;
            return 1'b0;
         end
         PH_DATA_LF: begin
            if (b != CH_LF) return raise_error(ERR_BAD_REQUEST, r);
            parse_phase   = PH_SIZE_START;
            chunk_left    = '0;
            line_bytes    = 0;
            crlf_progress = MATCH_NONE;
            return 1'b0;
         end
         PH_TRAILER: return trailer_step(b, r);
         PH_SIZE_START, PH_SIZE_DIGITS, PH_SIZE_BLANK, PH_SIZE_CR, PH_SIZE_EXT:
            return size_line_step(b, r);
         default: begin
            parse_phase = PH_SIZE_START;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   // Follow register writes and both channels at every clock edge.
   always @(posedge clock) begin
      body_result_type want;
      if (reset) begin
         body_kib_limit     = '0;
         trailer_byte_limit = TRAILER_LIMIT_RESET;
         clear_body_state();
         awaited_results.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MAX_BODY_KIB:      body_kib_limit     = csr_wdata[KIB_W-1:0];
               CSR_MAX_TRAILER_BYTES: trailer_byte_limit = csr_wdata[TRAILER_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (decode_item(req_action, req_in_byte, want)) awaited_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("result with no expectation waiting: kind %0d", rsp_kind);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 64'(want.kind), 64'(rsp_kind));
               check_field("out_byte", 64'(want.out_byte), 64'(rsp_out_byte));
               check_field("error_code", 64'(want.error_code), 64'(rsp_error_code));
               check_field("body_length", 64'(want.body_length), 64'(rsp_body_length));
               check_field("keep_alive_dropped", 64'(want.keep_alive_dropped),
                           64'(rsp_keep_alive_dropped));
            end
         end
      end
      expected_count <= awaited_results.size();
      fail_count     <= mismatches;
   end

endmodule

### tb/tb_top.sv
// Top of the chunked body decoder testbench: clock, reset, stimulus and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hcbd_pkg::*;

   localparam string CRLF_TEXT = "\015\n";
   localparam string CR_TEXT   = "\015";

   logic                   clock                  = 1'b0;
   logic                   reset                  = 1'b1;
   logic                   req_valid              = 1'b0;
   logic                   req_stall;
   logic                   req_action             = ACT_BYTE;
   logic [BYTE_W-1:0]      req_in_byte            = '0;
   logic                   rsp_valid;
   logic                   rsp_stall              = 1'b0;
   logic [KIND_W-1:0]      rsp_kind;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_error_code;
   logic [TOTAL_W-1:0]     rsp_body_length;
   logic                   rsp_keep_alive_dropped;
   logic                   csr_write              = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index              = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata              = '0;
   int                     expected_count;
   int                     fail_count;

   // No idling on either side while this is set.
   bit                     quiet = 1'b0;

   // Bytes of the random body being built.
   logic [BYTE_W-1:0]      wire_bytes[$];

   http_chunked_body_decoder dut (.*);

   chunked_decode_checker decode_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // The result side stalls now and then.
   initial begin
      forever begin
         @(posedge clock);
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 6);
      end
   end

   initial begin
      #4_000_000;
      $display("http_chunked_body_decoder regression: fail");
      $finish;
   end

   // Offers one item, with occasional idle cycles first, and waits until it is taken.
   task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
      while (!quiet && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic start_body();
      send_item(ACT_BEGIN, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_item(ACT_BYTE, s[i]);
   endtask

   // Stops sending and waits until every expected result has come.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic void put_text(input string s);
      foreach (s[i]) wire_bytes.push_back(s[i]);
   endfunction

   // Appends a size line in random form; returns 1 when it ends with CR LF.
   function automatic bit put_size_line(input longint unsigned chunk_size);
      int          digits;
      int unsigned d;
      bit          upper;
      bit          with_cr;
      upper  = 1'($urandom_range(0, 1));
      digits = 1;
      while (digits < 16 && (chunk_size >> (4 * digits)) != 0) digits++;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0) wire_bytes.push_back("0");
      for (int i = digits - 1; i >= 0; i--) begin
         d = 32'((chunk_size >> (4 * i)) & 64'd15);
         wire_bytes.push_back(d < 10 ? 8'(8'h30 + d) : 8'((upper ? 8'h41 : 8'h61) + d - 10));
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 2)) wire_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      end
      with_cr = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
         wire_bytes.push_back(CH_SEMI);
         repeat ($urandom_range(0, 6)) wire_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
         with_cr = 1'($urandom_range(0, 1));
      end
      if (with_cr) wire_bytes.push_back(CH_CR);
      wire_bytes.push_back(CH_LF);
      return with_cr;
   endfunction

   // Builds a random body, mostly well formed, sometimes broken, and sends it.
   task automatic send_random_body(inout int sent);
      int unsigned pick;
      int unsigned chunk_size;
      int unsigned lines;
      bit          crlf_end;
      wire_bytes.delete();
      repeat ($urandom_range(0, 3)) begin
         chunk_size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 600) : $urandom_range(1, 12);
         void'(put_size_line(64'(chunk_size)));
         repeat (chunk_size) wire_bytes.push_back(8'($urandom_range(0, 255)));
         put_text(CRLF_TEXT);
      end
      crlf_end = put_size_line(64'd0);
      lines    = $urandom_range(0, 2);
      // A bare LF does not start the terminator, so an empty trailer needs one more line end.
      if (lines == 0 && !crlf_end) put_text(CRLF_TEXT);
      repeat (lines) begin
         put_text("X-");
         repeat ($urandom_range(1, 6)) wire_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
         put_text({": v", CRLF_TEXT});
      end
      put_text(CRLF_TEXT);

      // Damage some bodies: a wrong byte, a cut, a huge size or plain noise.
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         wire_bytes[$urandom_range(0, wire_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 18) begin
         wire_bytes = wire_bytes[0:$urandom_range(0, wire_bytes.size() - 1)];
      end else if (pick < 24) begin
         wire_bytes.delete();
         put_text({"ffffffff", CRLF_TEXT});
         repeat ($urandom_range(1, 6)) wire_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 28) begin
         wire_bytes.delete();
         repeat ($urandom_range(1, 8)) wire_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 3)) wire_bytes.push_back(8'($urandom_range(0, 255)));
      end

      start_body();
      foreach (wire_bytes[i]) send_item(ACT_BYTE, wire_bytes[i]);
      sent += wire_bytes.size() + 1;
   endtask

   initial begin
      int                    sent;
      logic [CSR_DATA_W-1:0] kib_setting;
      logic [CSR_DATA_W-1:0] trailer_setting;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Well-formed bodies: blanks, both byte extremes, extensions with bare LF and with CR LF.
      start_body();
      send_text({"2 \t", CRLF_TEXT});
      send_item(ACT_BYTE, 8'h00);
      send_item(ACT_BYTE, 8'hFF);
      send_text({CRLF_TEXT, "0;x=1\n", CRLF_TEXT, CRLF_TEXT});
      // Bytes after the end of a body are ignored.
      send_text("zz");
      start_body();
      send_text({"A;e", CRLF_TEXT, "0123456789", CRLF_TEXT, "0;e", CRLF_TEXT});
      send_text({"T: v", CRLF_TEXT, CRLF_TEXT});

      // Bad requests: no digits, a stray byte after the digits, no LF after CR,
      // and a payload that is not closed by CR LF.
      start_body();
      send_text("g");
      start_body();
      send_text("1x");
      start_body();
      send_text({"1 ", CR_TEXT, "x"});
      start_body();
      send_text({"1", CRLF_TEXT, "ab"});
      start_body();
      send_text({"1", CRLF_TEXT, "a", CR_TEXT, "b"});

      // Hex overflow on the sixteenth digit, then the largest size that still fits.
      start_body();
      send_text("ffffffffffffffff");
      start_body();
      send_text({"7ffffffffffffffF", CRLF_TEXT, "q"});
      // An unlimited body whose total would pass 2^63-1.
      start_body();
      send_text({"1", CRLF_TEXT, "q", CRLF_TEXT, "7fffffffffffffff", CRLF_TEXT});

      // A size line of 1023 bytes passes, one of 1024 bytes fails on its last byte.
      start_body();
      send_text("1;");
      repeat (1019) send_item(ACT_BYTE, "a");
      send_text({CRLF_TEXT, "q", CRLF_TEXT, "0", CRLF_TEXT, CRLF_TEXT});
      start_body();
      send_text("1;");
      repeat (1020) send_item(ACT_BYTE, "a");
      send_text(CRLF_TEXT);

      // Size limit at one KiB and at the largest setting.
      write_reg(CSR_MAX_BODY_KIB, 22'd1);
      start_body();
      send_text({"401", CRLF_TEXT});
      start_body();
      send_text({"400", CRLF_TEXT, "q"});
      write_reg(CSR_MAX_BODY_KIB, 22'h3F_FFFF);
      start_body();
      send_text({"100000000", CRLF_TEXT});
      start_body();
      send_text({"fffffc00", CRLF_TEXT, "q"});

      // Trailer limits at both extremes.
      write_reg(CSR_MAX_TRAILER_BYTES, 22'd1);
      start_body();
      send_text({"0", CRLF_TEXT, CRLF_TEXT});
      start_body();
      send_text("0;q\na");
      write_reg(CSR_MAX_TRAILER_BYTES, 22'd65535);
      start_body();
      send_text({"0", CRLF_TEXT, "abc", CRLF_TEXT, CRLF_TEXT});

      // Random bodies under several settings; the third runs with no idling at all.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               kib_setting     = 22'd0;
               trailer_setting = 22'd8192;
            end
            1: begin
               kib_setting     = 22'd1;
               trailer_setting = 22'd1;
            end
            2: begin
               kib_setting     = 22'h3F_FFFF;
               trailer_setting = 22'd65535;
            end
            default: begin
               kib_setting     = 22'($urandom_range(1, 3));
               trailer_setting = 22'($urandom_range(2, 40));
            end
         endcase
         write_reg(CSR_MAX_BODY_KIB, kib_setting);
         write_reg(CSR_MAX_TRAILER_BYTES, trailer_setting);
         quiet = (p == 2);
         sent  = 0;
         while (sent < 200) send_random_body(sent);
      end
      quiet = 1'b0;

      wait_drained();
      if (fail_count == 0) begin
         $display("http_chunked_body_decoder regression: pass");
      end else begin
         $display("http_chunked_body_decoder regression: fail");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/hcbd_pkg.sv
src/http_chunked_body_decoder.sv
tb/chunked_decode_checker.sv
tb/tb_top.sv
